// ===== rtl/amt_pkg.sv =====
// shared constants, state codes and the helper function of the adaptive mean threshold block
// no dependencies
package amt_pkg;

    localparam int COL_W    = 10;
    localparam int ROW_W    = 12;
    localparam int WID_W    = 11;
    localparam int HGT_W    = 13;
    localparam int RAD_W    = 3;
    localparam int OFS_W    = 9;
    localparam int SLOT_W   = 4;
    localparam int ADDR_W   = SLOT_W + COL_W;
    localparam int SUM_W    = 16;
    localparam int CNT_W    = 8;
    localparam int CFG_W    = 13;
    localparam int IDX_W    = 2;
    localparam int DIV_STEPS = SUM_W;

    localparam logic [WID_W-1:0] MAX_WIDTH    = 11'd1024;
    localparam logic [HGT_W-1:0] HEIGHT_LIMIT = 13'd4096;
    localparam logic [RAD_W-1:0] MAX_RADIUS   = 3'd7;

    localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [IDX_W-1:0] REG_RADIUS = 2'd2;
    localparam logic [IDX_W-1:0] REG_OFFSET = 2'd3;

    localparam logic OP_PIXEL = 1'b0;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CHECK = 7'b0000010,
        S_SCAN  = 7'b0000100,
        S_SELF  = 7'b0001000,
        S_LOAD  = 7'b0010000,
        S_DIV   = 7'b0100000,
        S_EMIT  = 7'b1000000
    } state_t;

    // gray = (r + g + b) / 3 by reciprocal multiply, exact for sums up to 765
    function automatic logic [7:0] gray_of(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b);
        logic [9:0]  s;
        logic [19:0] p;
        s = {2'b00, r} + {2'b00, g} + {2'b00, b};
        p = s * 10'd683;
        return p[18:11];
    endfunction

endpackage

// ===== rtl/amt_pixel_if.sv =====
// pixel request channel of the adaptive mean threshold block
// depends on nothing
interface amt_pixel_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, operation, red, green, blue, input ready);
    modport sink   (input valid, operation, red, green, blue, output ready);
endinterface

// ===== rtl/amt_result_if.sv =====
// result request channel of the adaptive mean threshold block
// depends on nothing
interface amt_result_if;
    logic valid;
    logic ready;
    logic is_white;
    logic last_in_frame;

    modport source (output valid, is_white, last_in_frame, input ready);
    modport sink   (input valid, is_white, last_in_frame, output ready);
endinterface

// ===== rtl/amt_line_store.sv =====
// gray line store: sixteen row slots of 1024 pixels, one write and one registered read port
// depends on amt_pkg
module amt_line_store (
    input  logic                       clk,
    input  logic                       we,
    input  logic [amt_pkg::ADDR_W-1:0] waddr,
    input  logic [7:0]                 wdata,
    input  logic [amt_pkg::ADDR_W-1:0] raddr,
    output logic [7:0]                 rdata
);

    logic [7:0] mem [0:(1 << amt_pkg::ADDR_W)-1];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/amt_divider.sv =====
// restoring divider for window sum over pixel count, one quotient bit per cycle
// depends on amt_pkg
module amt_divider (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [amt_pkg::SUM_W-1:0] dividend,
    input  logic [amt_pkg::CNT_W-1:0] divisor,
    output logic                      done,
    output logic [7:0]                quotient
);

    logic [amt_pkg::SUM_W-1:0] quo_reg, quo_next;
    logic [amt_pkg::CNT_W-1:0] rem_reg, rem_next;
    logic [amt_pkg::CNT_W-1:0] dvs_reg, dvs_next;
    logic [4:0]                step_reg, step_next;
    logic                      busy_reg, busy_next;
    logic [amt_pkg::CNT_W:0]   trial;

    // one restoring step per cycle
    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        trial     = {rem_reg, quo_reg[amt_pkg::SUM_W-1]};
        done      = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = amt_pkg::CNT_W'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[amt_pkg::SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[amt_pkg::CNT_W-1:0];
                quo_next = {quo_reg[amt_pkg::SUM_W-2:0], 1'b0};
            end
            step_next = step_reg + 5'd1;
            if (step_reg == 5'(amt_pkg::DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done      = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    // quotient is the mean, never above 255
    assign quotient = quo_next[7:0];

endmodule

// ===== rtl/adaptive_mean_threshold.sv =====
// Adaptive mean threshold over a raster RGB stream. Each pixel request turns the pixel into
// gray and, while the frame is still coming in, writes it to the line store; when the window
// of the oldest pending pixel is complete, the block reads that window from the line store one
// entry per cycle, reads the pixel itself, divides the sum by the in-frame pixel count in a
// bit-serial divider and emits one result, after any wait for the previous result to be taken.
// The window is clipped at the frame edges, up to 225 pixels at radius 7 and 9 at radius 1;
// the scan is paced by the single read port of the line store. Drain requests flush pending
// results at the end of a frame. A new request is accepted only in the idle state.
// Any configuration write restarts the frame.
// depends on amt_pkg, amt_pixel_if, amt_result_if, amt_line_store, amt_divider
module adaptive_mean_threshold (
    input  logic                       clk,
    input  logic                       rst_n,
    amt_pixel_if.sink                  px,
    amt_result_if.source               res,
    input  logic                       cfg_we,
    input  logic [amt_pkg::IDX_W-1:0]  cfg_index,
    input  logic [amt_pkg::CFG_W-1:0]  cfg_data
);

    amt_pkg::state_t state_reg, state_next;

    logic [amt_pkg::WID_W-1:0] width_reg,  width_next;
    logic [amt_pkg::HGT_W-1:0] height_reg, height_next;
    logic [amt_pkg::RAD_W-1:0] radius_reg, radius_next;
    logic [amt_pkg::OFS_W-1:0] offset_reg, offset_next;

    logic [amt_pkg::COL_W-1:0] in_col_reg,  in_col_next;
    logic [amt_pkg::ROW_W-1:0] in_row_reg,  in_row_next;
    logic [amt_pkg::COL_W-1:0] out_col_reg, out_col_next;
    logic [amt_pkg::ROW_W-1:0] out_row_reg, out_row_next;
    logic                      frame_in_reg, frame_in_next;

    logic [amt_pkg::COL_W-1:0] sc_reg,  sc_next;
    logic [amt_pkg::ROW_W-1:0] sr_reg,  sr_next;
    logic [amt_pkg::COL_W-1:0] clo_reg, clo_next;
    logic [amt_pkg::COL_W-1:0] chi_reg, chi_next;
    logic [amt_pkg::ROW_W-1:0] rhi_reg, rhi_next;
    logic [amt_pkg::SUM_W-1:0] sum_reg, sum_next;
    logic [amt_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [7:0]                self_reg, self_next;
    logic                      rd_vld_reg;

    logic res_valid_reg, res_valid_next;
    logic res_white_reg, res_white_next;
    logic res_last_reg,  res_last_next;

    logic                       px_acc;
    logic                       wr_en;
    logic [7:0]                 gray;
    logic [amt_pkg::ADDR_W-1:0] raddr;
    logic [7:0]                 rdata;
    logic                       div_start;
    logic                       div_done;
    logic [7:0]                 mean;

    logic [amt_pkg::COL_W-1:0] w_last;
    logic [amt_pkg::ROW_W-1:0] h_last;
    logic [amt_pkg::HGT_W-1:0] row_hi_raw;
    logic [amt_pkg::WID_W-1:0] col_hi_raw;
    logic [amt_pkg::ROW_W-1:0] nr;
    logic [amt_pkg::COL_W-1:0] nc;
    logic                      out_ready;
    logic                      white;
    logic                      scan_last;
    logic [10:0]               thresh;

    assign px_acc = px.valid && px.ready;
    assign px.ready = (state_reg == amt_pkg::S_IDLE);
    assign wr_en  = px_acc && (px.operation == amt_pkg::OP_PIXEL) && !frame_in_reg;
    assign gray   = amt_pkg::gray_of(px.red, px.green, px.blue);

    // window bounds of the current output pixel
    assign w_last     = amt_pkg::COL_W'(width_reg - 11'd1);
    assign h_last     = amt_pkg::ROW_W'(height_reg - 13'd1);
    assign row_hi_raw = {1'b0, out_row_reg} + amt_pkg::HGT_W'(radius_reg);
    assign col_hi_raw = {1'b0, out_col_reg} + amt_pkg::WID_W'(radius_reg);
    assign nr = (row_hi_raw > {1'b0, h_last}) ? h_last : row_hi_raw[amt_pkg::ROW_W-1:0];
    assign nc = (col_hi_raw > {1'b0, w_last}) ? w_last : col_hi_raw[amt_pkg::COL_W-1:0];
    assign out_ready = frame_in_reg || (nr < in_row_reg) ||
                       ((nr == in_row_reg) && (nc < in_col_reg));

    assign scan_last = (sc_reg == chi_reg) && (sr_reg == rhi_reg);
    assign div_start = (state_reg == amt_pkg::S_LOAD);

    // black when self < mean - offset
    assign thresh = {3'b000, mean} - {{2{offset_reg[amt_pkg::OFS_W-1]}}, offset_reg};
    assign white  = !($signed({3'b000, self_reg}) < $signed(thresh));

    // read address: window entries while scanning, the pixel itself afterwards
    always_comb
    begin
        if (state_reg == amt_pkg::S_SELF)
        begin
            raddr = {out_row_reg[amt_pkg::SLOT_W-1:0], out_col_reg};
        end
        else
        begin
            raddr = {sr_reg[amt_pkg::SLOT_W-1:0], sc_reg};
        end
    end

    amt_line_store u_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr ({in_row_reg[amt_pkg::SLOT_W-1:0], in_col_reg}),
        .wdata (gray),
        .raddr (raddr),
        .rdata (rdata)
    );

    amt_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (cnt_reg),
        .done     (div_done),
        .quotient (mean)
    );

    // sequencer, counters and configuration
    always_comb
    begin
        state_next     = state_reg;
        width_next     = width_reg;
        height_next    = height_reg;
        radius_next    = radius_reg;
        offset_next    = offset_reg;
        in_col_next    = in_col_reg;
        in_row_next    = in_row_reg;
        out_col_next   = out_col_reg;
        out_row_next   = out_row_reg;
        frame_in_next  = frame_in_reg;
        sc_next        = sc_reg;
        sr_next        = sr_reg;
        clo_next       = clo_reg;
        chi_next       = chi_reg;
        rhi_next       = rhi_reg;
        sum_next       = sum_reg;
        cnt_next       = cnt_reg;
        self_next      = self_reg;
        res_valid_next = res_valid_reg;
        res_white_next = res_white_reg;
        res_last_next  = res_last_reg;

        if (res_valid_reg && res.ready)
        begin
            res_valid_next = 1'b0;
        end

        // accumulate window data returning from the store
        if (rd_vld_reg)
        begin
            sum_next = sum_reg + amt_pkg::SUM_W'(rdata);
        end

        unique case (state_reg)
            amt_pkg::S_IDLE:
            begin
                if (px_acc)
                begin
                    if (wr_en)
                    begin
                        if ({1'b0, in_col_reg} + 11'd1 >= width_reg)
                        begin
                            in_col_next = '0;
                            if ({1'b0, in_row_reg} + 13'd1 >= height_reg)
                            begin
                                in_row_next   = '0;
                                frame_in_next = 1'b1;
                            end
                            else
                            begin
                                in_row_next = in_row_reg + 12'd1;
                            end
                        end
                        else
                        begin
                            in_col_next = in_col_reg + 10'd1;
                        end
                    end
                    state_next = amt_pkg::S_CHECK;
                end
            end
            amt_pkg::S_CHECK:
            begin
                if (out_ready)
                begin
                    sr_next  = (out_row_reg >= 12'(radius_reg)) ?
                               out_row_reg - 12'(radius_reg) : '0;
                    sc_next  = (out_col_reg >= 10'(radius_reg)) ?
                               out_col_reg - 10'(radius_reg) : '0;
                    clo_next = (out_col_reg >= 10'(radius_reg)) ?
                               out_col_reg - 10'(radius_reg) : '0;
                    chi_next = nc;
                    rhi_next = nr;
                    sum_next = '0;
                    cnt_next = '0;
                    state_next = amt_pkg::S_SCAN;
                end
                else
                begin
                    state_next = amt_pkg::S_IDLE;
                end
            end
            amt_pkg::S_SCAN:
            begin
                cnt_next = cnt_reg + 8'd1;
                if (scan_last)
                begin
                    state_next = amt_pkg::S_SELF;
                end
                else if (sc_reg == chi_reg)
                begin
                    sc_next = clo_reg;
                    sr_next = sr_reg + 12'd1;
                end
                else
                begin
                    sc_next = sc_reg + 10'd1;
                end
            end
            amt_pkg::S_SELF:
            begin
                state_next = amt_pkg::S_LOAD;
            end
            amt_pkg::S_LOAD:
            begin
                self_next  = rdata;
                state_next = amt_pkg::S_DIV;
            end
            amt_pkg::S_DIV:
            begin
                if (div_done)
                begin
                    state_next = amt_pkg::S_EMIT;
                end
            end
            amt_pkg::S_EMIT:
            begin
                // the divider holds its quotient until the next start
                if (!res_valid_reg || res.ready)
                begin
                    res_valid_next = 1'b1;
                    res_white_next = white;
                    state_next     = amt_pkg::S_IDLE;
                    if ((out_row_reg == h_last) && (out_col_reg == w_last))
                    begin
                        res_last_next = 1'b1;
                        in_col_next   = '0;
                        in_row_next   = '0;
                        out_col_next  = '0;
                        out_row_next  = '0;
                        frame_in_next = 1'b0;
                    end
                    else
                    begin
                        res_last_next = 1'b0;
                        if (out_col_reg == w_last)
                        begin
                            out_col_next = '0;
                            out_row_next = out_row_reg + 12'd1;
                        end
                        else
                        begin
                            out_col_next = out_col_reg + 10'd1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = amt_pkg::S_IDLE;
            end
        endcase

        // register writes clamp width, height and radius and restart the frame
        if (cfg_we)
        begin
            unique case (cfg_index)
                amt_pkg::REG_WIDTH:
                begin
                    if (cfg_data[10:0] == '0)
                        width_next = 11'd1;
                    else if (cfg_data[10:0] > amt_pkg::MAX_WIDTH)
                        width_next = amt_pkg::MAX_WIDTH;
                    else
                        width_next = cfg_data[10:0];
                end
                amt_pkg::REG_HEIGHT:
                begin
                    if (cfg_data == '0)
                        height_next = 13'd1;
                    else if (cfg_data > amt_pkg::HEIGHT_LIMIT)
                        height_next = amt_pkg::HEIGHT_LIMIT;
                    else
                        height_next = cfg_data;
                end
                amt_pkg::REG_RADIUS:
                begin
                    radius_next = (cfg_data[2:0] > amt_pkg::MAX_RADIUS) ?
                                  amt_pkg::MAX_RADIUS : cfg_data[2:0];
                end
                amt_pkg::REG_OFFSET:
                begin
                    offset_next = cfg_data[8:0];
                end
                default:
                begin
                    offset_next = offset_reg;
                end
            endcase
            in_col_next   = '0;
            in_row_next   = '0;
            out_col_next  = '0;
            out_row_next  = '0;
            frame_in_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= amt_pkg::S_IDLE;
            width_reg     <= amt_pkg::MAX_WIDTH;
            height_reg    <= 13'd768;
            radius_reg    <= 3'd1;
            offset_reg    <= '0;
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            frame_in_reg  <= 1'b0;
            rd_vld_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            radius_reg    <= radius_next;
            offset_reg    <= offset_next;
            in_col_reg    <= in_col_next;
            in_row_reg    <= in_row_next;
            out_col_reg   <= out_col_next;
            out_row_reg   <= out_row_next;
            frame_in_reg  <= frame_in_next;
            rd_vld_reg    <= (state_reg == amt_pkg::S_SCAN);
            res_valid_reg <= res_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        sc_reg        <= sc_next;
        sr_reg        <= sr_next;
        clo_reg       <= clo_next;
        chi_reg       <= chi_next;
        rhi_reg       <= rhi_next;
        sum_reg       <= sum_next;
        cnt_reg       <= cnt_next;
        self_reg      <= self_next;
        res_white_reg <= res_white_next;
        res_last_reg  <= res_last_next;
    end

    assign res.valid         = res_valid_reg;
    assign res.is_white      = res_white_reg;
    assign res.last_in_frame = res_last_reg;

    // the divider never starts on an empty window
    assert property (@(posedge clk) disable iff (!rst_n) div_start |-> (cnt_reg != '0))
        else $error("divide started with zero count");

    // a divider result only arrives while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == amt_pkg::S_DIV))
        else $error("divider finished outside divide state");

    // an accepted request always leaves the idle state
    assert property (@(posedge clk) disable iff (!rst_n)
        px_acc |=> (state_reg == amt_pkg::S_CHECK))
        else $error("accepted request not checked");

    // a new result is only loaded into an empty or draining output register
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == amt_pkg::S_EMIT && res_valid_reg && !res.ready) |=>
        (state_reg == amt_pkg::S_EMIT))
        else $error("result overwritten while stalled");

endmodule
